// File: src/piso_chain_scan_reader_defines.svh
// Assertion helpers shared by the chain reader.
`ifndef PISO_CHAIN_SCAN_READER_DEFINES_SVH
`define PISO_CHAIN_SCAN_READER_DEFINES_SVH

// same-cycle implication
`define PCSR_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pcsr check failed");

// next-cycle implication
`define PCSR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pcsr check failed");

`endif

// File: src/pcsr_pkg.sv
package pcsr_pkg;

  localparam int MAX_CHIPS = 8;
  localparam int IDX_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int CNT_W     = $clog2(MAX_CHIPS + 1);

  // action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SCAN = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // scan phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOAD = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_HALF    = 3'd0;
  localparam logic [2:0] REG_LOAD    = 3'd1;
  localparam logic [2:0] REG_LSB     = 3'd2;
  localparam logic [2:0] REG_REVERSE = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;

  localparam logic [7:0] BIT_MSB = 8'h80;
  localparam logic [7:0] BIT_LSB = 8'h01;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] load_ticks;
    logic        lsb_first;
    logic        chip_reverse;
    logic [3:0]  chip_count;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic clock_level;
    logic load_level;
    logic busy;
  } stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic       error;
  } rd_t;

  // 0 acts as 1, anything above the chain length as the chain length
  function automatic logic [CNT_W-1:0] active_chips(input logic [3:0] cc);
    logic [CNT_W-1:0] n;
    if (cc == 4'd0) n = CNT_W'(1);
    else if (int'(cc) > MAX_CHIPS) n = CNT_W'(MAX_CHIPS);
    else n = CNT_W'(cc);
    return n;
  endfunction

endpackage

// File: src/pcsr_seq.sv
`include "piso_chain_scan_reader_defines.svh"

module pcsr_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [1:0]                 action,
  input  logic                       data_pin,
  input  pcsr_pkg::cfg_t             cfg,
  input  logic [pcsr_pkg::CNT_W-1:0] n,
  output pcsr_pkg::stat_t            stat,
  output pcsr_pkg::wr_t              wr
);

  localparam logic [pcsr_pkg::CNT_W-1:0] CNT_ONE = pcsr_pkg::CNT_W'(1);

  logic [1:0]                 scan_phase, scan_phase_next;
  logic [15:0]                wait_count, wait_count_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic [2:0]                 bit_index, bit_index_next;
  logic [pcsr_pkg::CNT_W-1:0] chip_index, chip_index_next;
  logic                       clock_level, clock_level_next;
  logic                       load_level, load_level_next;
  logic [7:0]                 bit_mask, sampled;
  logic [pcsr_pkg::CNT_W-1:0] slot;

  assign bit_mask = cfg.lsb_first ? (pcsr_pkg::BIT_LSB << bit_index)
                                  : (pcsr_pkg::BIT_MSB >> bit_index);
  assign sampled  = shift_byte | (data_pin ? bit_mask : 8'h00);
  assign slot     = cfg.chip_reverse ? (n - CNT_ONE - chip_index) : chip_index;

  always_comb begin
    scan_phase_next  = scan_phase;
    wait_count_next  = wait_count;
    shift_byte_next  = shift_byte;
    bit_index_next   = bit_index;
    chip_index_next  = chip_index;
    clock_level_next = clock_level;
    load_level_next  = load_level;
    wr.en            = 1'b0;
    wr.idx           = slot[pcsr_pkg::IDX_W-1:0];
    wr.data          = sampled;
    if (action == pcsr_pkg::ACT_SCAN && scan_phase == pcsr_pkg::PH_IDLE) begin
      load_level_next = 1'b0;
      wait_count_next = (cfg.load_ticks == 16'd0) ? 16'd0 : cfg.load_ticks - 16'd1;
      scan_phase_next = pcsr_pkg::PH_LOAD;
      shift_byte_next = 8'h00;
      bit_index_next  = 3'd0;
      chip_index_next = '0;
    end else begin
      case (scan_phase)
        pcsr_pkg::PH_LOAD: begin
          if (wait_count != 16'd0) begin
            wait_count_next = wait_count - 16'd1;
          end else begin
            load_level_next = 1'b1;
            scan_phase_next = pcsr_pkg::PH_GAP;
            wait_count_next = 16'd0;
          end
        end
        pcsr_pkg::PH_LOW: begin
          if (wait_count != 16'd0) begin
            wait_count_next = wait_count - 16'd1;
          end else begin
            clock_level_next = 1'b1;
            scan_phase_next  = pcsr_pkg::PH_GAP;
            wait_count_next  = cfg.half_period_ticks;
          end
        end
        pcsr_pkg::PH_GAP: begin
          if (wait_count != 16'd0) begin
            wait_count_next = wait_count - 16'd1;
          end else if (chip_index >= n) begin
            scan_phase_next = pcsr_pkg::PH_IDLE;
          end else begin
            // sample before the falling clock edge
            if (bit_index == 3'd7) begin
              wr.en           = 1'b1;
              shift_byte_next = 8'h00;
              bit_index_next  = 3'd0;
              chip_index_next = chip_index + CNT_ONE;
            end else begin
              shift_byte_next = sampled;
              bit_index_next  = bit_index + 3'd1;
            end
            clock_level_next = 1'b0;
            scan_phase_next  = pcsr_pkg::PH_LOW;
            wait_count_next  = cfg.half_period_ticks;
          end
        end
        default: ;
      endcase
    end
    if (!step) wr.en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase  <= pcsr_pkg::PH_IDLE;
      wait_count  <= 16'd0;
      shift_byte  <= 8'h00;
      bit_index   <= 3'd0;
      chip_index  <= '0;
      clock_level <= 1'b0;
      load_level  <= 1'b1;
    end else if (step) begin
      scan_phase  <= scan_phase_next;
      wait_count  <= wait_count_next;
      shift_byte  <= shift_byte_next;
      bit_index   <= bit_index_next;
      chip_index  <= chip_index_next;
      clock_level <= clock_level_next;
      load_level  <= load_level_next;
    end
  end

  assign stat.clock_level = clock_level_next;
  assign stat.load_level  = load_level_next;
  assign stat.busy        = (scan_phase_next != pcsr_pkg::PH_IDLE);

  `PCSR_ASSERT_NOW(a_load_only_in_load, clk, rst, !load_level, scan_phase == pcsr_pkg::PH_LOAD)
  `PCSR_ASSERT_NOW(a_chip_in_range, clk, rst, 1'b1, int'(chip_index) <= pcsr_pkg::MAX_CHIPS)
  `PCSR_ASSERT_NEXT(a_start_loads, clk, rst, step && action == pcsr_pkg::ACT_SCAN && scan_phase == pcsr_pkg::PH_IDLE, scan_phase == pcsr_pkg::PH_LOAD && !load_level && bit_index == 3'd0)

endmodule

// File: src/pcsr_cache.sv
module pcsr_cache (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  pcsr_pkg::wr_t              wr,
  input  logic [1:0]                 action,
  input  logic [7:0]                 chip,
  input  logic [7:0]                 pin_mask,
  input  logic [pcsr_pkg::CNT_W-1:0] n,
  output pcsr_pkg::rd_t              rd
);

  logic [7:0] pin_cache [pcsr_pkg::MAX_CHIPS];
  logic [7:0] cur_byte;
  logic       miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcsr_pkg::MAX_CHIPS; i++) pin_cache[i] <= 8'h00;
    end else if (step && wr.en) begin
      pin_cache[wr.idx] <= wr.data;
    end
  end

  // the read sees a byte stored on the same tick
  assign cur_byte = (wr.en && wr.idx == chip[pcsr_pkg::IDX_W-1:0]) ? wr.data
                  : pin_cache[chip[pcsr_pkg::IDX_W-1:0]];
  assign miss     = (chip >= 8'(n));

  assign rd.valid = (action == pcsr_pkg::ACT_READ);
  assign rd.error = rd.valid && miss;
  assign rd.value = (rd.valid && !miss) ? (cur_byte & pin_mask) : 8'h00;

endmodule

// File: src/piso_chain_scan_reader.sv
// A request's result is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle; in_ready drops only while a result is
// held back by out_ready low (single output register).
// Each accepted request is one tick of the pin-level scan sequencer.
// Synchronous reset: cache cleared, scan idle, load high, clock low,
// registers back to their default values.
module piso_chain_scan_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic        data_pin,
  input  logic [7:0]  chip,
  input  logic [7:0]  pin_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        shift_clock,
  output logic        load_n,
  output logic        busy_res,
  output logic        read_valid,
  output logic [7:0]  read_value,
  output logic        read_error
);

  pcsr_pkg::cfg_t             cfg;
  pcsr_pkg::stat_t            stat;
  pcsr_pkg::wr_t              wr;
  pcsr_pkg::rd_t              rd;
  logic [pcsr_pkg::CNT_W-1:0] n;
  logic                       step;
  logic [2:0]                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= 16'd4;
      cfg.load_ticks        <= 16'd1;
      cfg.lsb_first         <= 1'b0;
      cfg.chip_reverse      <= 1'b1;
      cfg.chip_count        <= 4'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        pcsr_pkg::REG_HALF:    cfg.half_period_ticks <= pwdata[15:0];
        pcsr_pkg::REG_LOAD:    cfg.load_ticks        <= pwdata[15:0];
        pcsr_pkg::REG_LSB:     cfg.lsb_first         <= pwdata[0];
        pcsr_pkg::REG_REVERSE: cfg.chip_reverse      <= pwdata[0];
        pcsr_pkg::REG_COUNT:   cfg.chip_count        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pcsr_pkg::REG_HALF:    prdata = 32'(cfg.half_period_ticks);
      pcsr_pkg::REG_LOAD:    prdata = 32'(cfg.load_ticks);
      pcsr_pkg::REG_LSB:     prdata = 32'(cfg.lsb_first);
      pcsr_pkg::REG_REVERSE: prdata = 32'(cfg.chip_reverse);
      pcsr_pkg::REG_COUNT:   prdata = 32'(cfg.chip_count);
      default:               prdata = 32'd0;
    endcase
  end

  assign n        = pcsr_pkg::active_chips(cfg.chip_count);
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  pcsr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (action),
    .data_pin (data_pin),
    .cfg      (cfg),
    .n        (n),
    .stat     (stat),
    .wr       (wr)
  );

  pcsr_cache u_cache (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .wr       (wr),
    .action   (action),
    .chip     (chip),
    .pin_mask (pin_mask),
    .n        (n),
    .rd       (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_clock <= stat.clock_level;
      load_n      <= stat.load_level;
      busy_res    <= stat.busy;
      read_valid  <= rd.valid;
      read_value  <= rd.value;
      read_error  <= rd.error;
    end
  end

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, behaves as a tick
  localparam int LONG_HOLD = 60;

  typedef struct {
    logic [1:0] action;
    logic       data_pin;
    logic [7:0] chip;
    logic [7:0] pin_mask;
  } pin_request_t;

  typedef struct {
    logic       shift_clock;
    logic       load_n;
    logic       busy;
    logic       read_valid;
    logic [7:0] read_value;
    logic       read_error;
  } pin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = pcsr_pkg::ACT_TICK;
  logic        data_pin = 1'b0;
  logic [7:0]  chip = '0;
  logic [7:0]  pin_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        shift_clock;
  logic        load_n;
  logic        busy_res;
  logic        read_valid;
  logic [7:0]  read_value;
  logic        read_error;

  piso_chain_scan_reader dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .data_pin(data_pin), .chip(chip), .pin_mask(pin_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .shift_clock(shift_clock), .load_n(load_n), .busy_res(busy_res),
    .read_valid(read_valid), .read_value(read_value), .read_error(read_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the register file
  logic [15:0] cfg_half = 16'd4;
  logic [15:0] cfg_load = 16'd1;
  logic        cfg_lsb = 1'b0;
  logic        cfg_rev = 1'b1;
  logic [3:0]  cfg_count = 4'd8;

  // predictor copy of the sequencer
  logic [7:0]  pin_cache [pcsr_pkg::MAX_CHIPS];
  logic [7:0]  shift_byte = '0;
  logic [2:0]  bit_idx = '0;
  int          chip_idx = 0;
  logic [1:0]  scan_ph = pcsr_pkg::PH_IDLE;
  logic [15:0] wait_cnt = '0;
  logic        clk_lvl = 1'b0;
  logic        load_lvl = 1'b1;

  pin_request_t pending_requests[$];
  pin_result_t  awaited_results[$];

  int unsigned fail_count = 0;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          stall_asks = 0;
  int          stall_served = 0;

  task automatic note_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // 0 counts as one chip, anything past the chain as the whole chain
  function automatic int live_chips();
    if (cfg_count == 4'd0) return 1;
    if (int'(cfg_count) > pcsr_pkg::MAX_CHIPS) return pcsr_pkg::MAX_CHIPS;
    return int'(cfg_count);
  endfunction

  task automatic take_sample(input logic d);
    int n;
    int slot;
    n = live_chips();
    if (d) shift_byte |= cfg_lsb ? (pcsr_pkg::BIT_LSB << bit_idx)
                                 : (pcsr_pkg::BIT_MSB >> bit_idx);
    if (bit_idx == 3'd7) begin
      // byte for a chip that is no longer active is dropped
      if (chip_idx < n) begin
        slot = cfg_rev ? n - 1 - chip_idx : chip_idx;
        if (slot < pcsr_pkg::MAX_CHIPS) pin_cache[slot] = shift_byte;
      end
      shift_byte = '0;
      bit_idx = '0;
      chip_idx++;
    end else begin
      bit_idx++;
    end
  endtask

  task automatic clock_sequencer(input logic d);
    case (scan_ph)
      pcsr_pkg::PH_LOAD: begin
        if (wait_cnt != 0) wait_cnt = wait_cnt - 16'd1;
        else begin
          load_lvl = 1'b1;
          scan_ph = pcsr_pkg::PH_GAP;
          wait_cnt = '0;
        end
      end
      pcsr_pkg::PH_LOW: begin
        if (wait_cnt != 0) wait_cnt = wait_cnt - 16'd1;
        else begin
          clk_lvl = 1'b1;
          scan_ph = pcsr_pkg::PH_GAP;
          wait_cnt = cfg_half;
        end
      end
      pcsr_pkg::PH_GAP: begin
        if (wait_cnt != 0) wait_cnt = wait_cnt - 16'd1;
        else if (chip_idx >= live_chips()) scan_ph = pcsr_pkg::PH_IDLE;
        else begin
          // sample before the clock falls
          take_sample(d);
          clk_lvl = 1'b0;
          scan_ph = pcsr_pkg::PH_LOW;
          wait_cnt = cfg_half;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_pins(input pin_request_t r, output pin_result_t res);
    if (r.action == pcsr_pkg::ACT_SCAN && scan_ph == pcsr_pkg::PH_IDLE) begin
      load_lvl = 1'b0;
      wait_cnt = (cfg_load == 0) ? 16'd0 : cfg_load - 16'd1;
      scan_ph = pcsr_pkg::PH_LOAD;
      shift_byte = '0;
      bit_idx = '0;
      chip_idx = 0;
    end else begin
      clock_sequencer(r.data_pin);
    end
    res.read_valid = (r.action == pcsr_pkg::ACT_READ);
    res.read_value = '0;
    res.read_error = 1'b0;
    if (r.action == pcsr_pkg::ACT_READ) begin
      if (int'(r.chip) >= live_chips() || int'(r.chip) >= pcsr_pkg::MAX_CHIPS)
        res.read_error = 1'b1;
      else res.read_value = pin_cache[r.chip] & r.pin_mask;
    end
    res.shift_clock = clk_lvl;
    res.load_n = load_lvl;
    res.busy = (scan_ph != pcsr_pkg::PH_IDLE);
  endtask

  // request driver
  always @(negedge clk) begin
    pin_request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        r = pending_requests.pop_front();
        action <= r.action;
        data_pin <= r.data_pin;
        chip <= r.chip;
        pin_mask <= r.pin_mask;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      req_taken = 1'b0;
    end
  end

  // result acceptance, with the long hold counted here
  always @(negedge clk) begin
    if (stall_asks != stall_served) begin
      hold_left = LONG_HOLD;
      stall_served = stall_asks;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict for the request taken this edge
  always @(posedge clk) begin
    pin_result_t want;
    pin_result_t fresh;
    pin_request_t r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("shift_clock", shift_clock, want.shift_clock);
          check_field("load_n", load_n, want.load_n);
          check_field("busy_res", busy_res, want.busy);
          check_field("read_valid", read_valid, want.read_valid);
          check_field("read_value", read_value, want.read_value);
          check_field("read_error", read_error, want.read_error);
        end
      end
      if (in_valid && in_ready) begin
        r.action = action;
        r.data_pin = data_pin;
        r.chip = chip;
        r.pin_mask = pin_mask;
        predict_pins(r, fresh);
        awaited_results.push_back(fresh);
        req_taken = 1'b1;
      end
    end
  end

  task automatic push_request(input logic [1:0] act, input logic d,
                              input logic [7:0] ch, input logic [7:0] mask);
    pin_request_t r;
    r.action = act;
    r.data_pin = d;
    r.chip = ch;
    r.pin_mask = mask;
    pending_requests.push_back(r);
  endtask

  task automatic wait_quiet();
    do begin
      @(posedge clk);
      #1;
    end while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      pcsr_pkg::REG_HALF:    cfg_half = value[15:0];
      pcsr_pkg::REG_LOAD:    cfg_load = value[15:0];
      pcsr_pkg::REG_LSB:     cfg_lsb = value[0];
      pcsr_pkg::REG_REVERSE: cfg_rev = value[0];
      pcsr_pkg::REG_COUNT:   cfg_count = value[3:0];
      default: ;
    endcase
  endtask

  // mostly ticks with random pin levels, some reads and noise
  task automatic push_scan_traffic(input int n, input bit restarts);
    int pick;
    logic [7:0] which;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      which = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
      if (pick < 8)
        push_request(pcsr_pkg::ACT_READ, 1'($urandom), which, 8'($urandom));
      else if (pick < 10)
        push_request(ACT_SPARE, 1'($urandom), which, 8'($urandom));
      else if (pick < 11 && restarts)
        push_request(pcsr_pkg::ACT_SCAN, 1'($urandom), which, 8'($urandom));
      else
        push_request(pcsr_pkg::ACT_TICK, 1'($urandom), which, 8'($urandom));
    end
  endtask

  task automatic finish_scan(input int batch, input bit restarts);
    do begin
      push_scan_traffic(batch, restarts);
      wait_quiet();
    end while (scan_ph != pcsr_pkg::PH_IDLE);
  endtask

  task automatic scan_once(input int batch, input bit restarts);
    push_request(pcsr_pkg::ACT_SCAN, 1'($urandom), 8'($urandom), 8'($urandom));
    finish_scan(batch, restarts);
  endtask

  task automatic read_back_all();
    for (int c = 0; c < pcsr_pkg::MAX_CHIPS + 2; c++)
      push_request(pcsr_pkg::ACT_READ, 1'($urandom), 8'(c),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
    wait_quiet();
  endtask

  initial begin
    for (int i = 0; i < pcsr_pkg::MAX_CHIPS; i++) pin_cache[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: reads of a clean cache, both error edges, odd codes
    push_request(pcsr_pkg::ACT_READ, 1'b0, 8'd0, 8'hFF);
    push_request(pcsr_pkg::ACT_READ, 1'b1, 8'd7, 8'hFF);
    push_request(pcsr_pkg::ACT_READ, 1'b0, 8'd8, 8'hFF);
    push_request(pcsr_pkg::ACT_READ, 1'b1, 8'd255, 8'hFF);
    push_request(ACT_SPARE, 1'b1, 8'd0, 8'h00);
    push_request(pcsr_pkg::ACT_TICK, 1'b1, 8'd0, 8'h00);
    push_request(pcsr_pkg::ACT_SCAN, 1'b1, 8'd0, 8'h00);
    push_request(pcsr_pkg::ACT_SCAN, 1'b0, 8'd0, 8'h00);  // ignored while busy
    push_request(pcsr_pkg::ACT_READ, 1'b1, 8'd0, 8'hFF);
    stall_asks++;  // long receiver hold while requests keep coming
    push_scan_traffic(40, 1'b0);
    wait_quiet();
    // shorten the running scan to one chip with no extra clock wait
    write_register(pcsr_pkg::REG_HALF, 32'd0);
    write_register(pcsr_pkg::REG_COUNT, 32'd1);
    finish_scan(16, 1'b0);
    read_back_all();

    // widest half period, kept idle so no scan waits it out
    write_register(pcsr_pkg::REG_HALF, 32'd65535);
    push_scan_traffic(12, 1'b0);
    wait_quiet();

    write_register(pcsr_pkg::REG_HALF, 32'd0);
    write_register(pcsr_pkg::REG_LOAD, 32'd0);
    write_register(pcsr_pkg::REG_LSB, 32'd1);
    write_register(pcsr_pkg::REG_REVERSE, 32'd0);
    write_register(pcsr_pkg::REG_COUNT, 32'd1);
    scan_once(16, 1'b0);
    read_back_all();

    write_register(pcsr_pkg::REG_COUNT, 32'd0);
    scan_once(16, 1'b0);
    read_back_all();

    // count above the chain, then cut down mid-scan
    write_register(pcsr_pkg::REG_COUNT, 32'd15);
    write_register(pcsr_pkg::REG_HALF, 32'd1);
    write_register(pcsr_pkg::REG_LSB, 32'd0);
    write_register(pcsr_pkg::REG_REVERSE, 32'd1);
    push_request(pcsr_pkg::ACT_SCAN, 1'b0, 8'd0, 8'h00);
    push_scan_traffic(40, 1'b0);
    wait_quiet();
    write_register(pcsr_pkg::REG_COUNT, 32'd1);
    finish_scan(16, 1'b0);
    read_back_all();

    repeat (3) begin
      write_register(pcsr_pkg::REG_HALF, $urandom_range(0, 1));
      write_register(pcsr_pkg::REG_LOAD, $urandom_range(0, 3));
      write_register(pcsr_pkg::REG_LSB, $urandom_range(0, 1));
      write_register(pcsr_pkg::REG_REVERSE, $urandom_range(0, 1));
      write_register(pcsr_pkg::REG_COUNT, $urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
        // leave the scan running into the next set of registers
        push_request(pcsr_pkg::ACT_SCAN, 1'b0, 8'd0, 8'h00);
        push_scan_traffic($urandom_range(20, 60), 1'b1);
        wait_quiet();
      end else begin
        scan_once(16, 1'b1);
        read_back_all();
      end
    end
    finish_scan(16, 1'b0);
    read_back_all();

    // no idling from here on; longest load pulse, left running
    calm = 1'b1;
    write_register(pcsr_pkg::REG_HALF, 32'd0);
    write_register(pcsr_pkg::REG_LOAD, 32'd65535);
    write_register(pcsr_pkg::REG_COUNT, 32'd1);
    push_request(pcsr_pkg::ACT_SCAN, 1'b1, 8'd0, 8'h00);
    push_scan_traffic(30, 1'b0);

    wait_quiet();
    repeat (5) @(posedge clk);
    if (awaited_results.size() != 0) note_mismatch("results still outstanding at the end");
    if (fail_count == 0) begin
      $display("piso_chain_scan_reader test passed");
    end else begin
      $display("piso_chain_scan_reader test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("piso_chain_scan_reader test failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/pcsr_pkg.sv
src/pcsr_seq.sv
src/pcsr_cache.sv
src/piso_chain_scan_reader.sv
bench/testbench.sv
